>>> sv/mrcr_pkg.sv
// Shared types and constants of the matrix row/column rotator.
package mrcr_pkg;

  typedef enum logic [2:0] {
    KIND_INIT   = 3'd0,
    KIND_LEFT   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_UP     = 3'd3,
    KIND_DOWN   = 3'd4,
    KIND_READ   = 3'd5
  } kind_t;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned LINE_W  = 4;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned VALUE_W = 9;
  localparam int unsigned SIZE_W  = 5;

  // Operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_FILL  = 3'd0,
    OP_ROT   = 3'd1,
    OP_READ  = 3'd2,
    OP_RDERR = 3'd3
  } op_t;

endpackage

>>> sv/matrix_row_column_rotator_top.sv
// Top level of the matrix row/column rotator.
// Command interface: an item is taken when start is high and busy low; a read returns one
// word marked by done, which the receiver must take in that cycle. After reset the cell
// memory loads its start values one cell a cycle; an item taken meanwhile waits in the
// front end. A read waits in the front end's output state, then the back end's read state
// registers the word and done together. An initialise holds the back end while it fills
// the N*N cells, one cell a cycle. A rotation first reduces its 16-bit amount bit-serially
// in the front end, then, unless the reduced amount is zero, the back end reads the N
// entries of the line into a line buffer at rotated positions, passes a turnaround
// state, writes the N entries back and makes a last write. busy covers the front end
// only, which holds one decoded item while the back end works. Rotations of a line not
// below N and unused kinds produce no word.
module matrix_row_column_rotator_top #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mrcr_pkg::KIND_W-1:0]   kind,
  input  logic [mrcr_pkg::LINE_W-1:0]   line_index,
  input  logic [mrcr_pkg::AMT_W-1:0]    shift_amount,
  input  logic [mrcr_pkg::LINE_W-1:0]   read_column,
  input  logic                          cfg_we,
  input  logic [mrcr_pkg::SIZE_W-1:0]   cfg_wdata,
  output logic                          done,
  output logic [mrcr_pkg::VALUE_W-1:0]  entry_value,
  output logic                          index_error
);
  import mrcr_pkg::*;

  localparam int unsigned IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);

  logic [SIZE_W-1:0] matrix_size;
  logic [SIDE_W-1:0] side;
  logic              f_ready, q_valid, q_ready, q_col, q_high;
  logic [2:0]        q_op;
  logic [IDX_W-1:0]  q_line, q_rcol, q_shift;

  always_ff @(posedge clk) begin
    if (rst) matrix_size <= SIZE_W'(16);
    else if (cfg_we) matrix_size <= cfg_wdata;
  end

  always_comb begin
    if (matrix_size == '0) side = SIDE_W'(1);
    else if (32'(matrix_size) > MAX_SIDE) side = SIDE_W'(MAX_SIDE);
    else side = SIDE_W'(matrix_size);
  end

  assign busy = !f_ready;

  mrcr_front #(.IDX_W(IDX_W), .SIDE_W(SIDE_W)) u_front (
    .clk, .rst, .in_valid(start), .in_ready(f_ready), .kind, .line_index,
    .shift_amount, .read_column, .side, .q_valid, .q_ready, .q_op, .q_col,
    .q_high, .q_line, .q_rcol, .q_shift
  );

  mrcr_back #(.MAX_SIDE(MAX_SIDE), .IDX_W(IDX_W), .SIDE_W(SIDE_W)) u_back (
    .clk, .rst, .side, .q_valid, .q_ready, .q_op, .q_col, .q_high, .q_line,
    .q_rcol, .q_shift, .done, .entry_value, .index_error
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && index_error |-> entry_value == '0) else $error("error word carries data");
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_op == OP_ROT |-> {1'b0, q_shift} < (IDX_W+1)'(side))
    else $error("shift not reduced");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("back-to-back result words");
`endif
endmodule

>>> sv/mrcr_front.sv
// Front end: decode items, check indexes, reduce the shift amount modulo the side.
module mrcr_front #(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned SIDE_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mrcr_pkg::KIND_W-1:0]   kind,
  input  logic [mrcr_pkg::LINE_W-1:0]   line_index,
  input  logic [mrcr_pkg::AMT_W-1:0]    shift_amount,
  input  logic [mrcr_pkg::LINE_W-1:0]   read_column,
  input  logic [SIDE_W-1:0]             side,
  output logic                          q_valid,
  input  logic                          q_ready,
  output logic [2:0]                    q_op,
  output logic                          q_col,
  output logic                          q_high,
  output logic [IDX_W-1:0]              q_line,
  output logic [IDX_W-1:0]              q_rcol,
  output logic [IDX_W-1:0]              q_shift
);
  import mrcr_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_OUT  = 3'b100
  } fstate_t;

  fstate_t              state;
  logic [AMT_W-1:0]     rem;
  logic [AMT_W+SIDE_W-1:0] dsub;
  logic [4:0]           bitpos;
  logic [2:0]           op;
  logic                 col, high;
  logic [LINE_W-1:0]    line_r, rcol_r;
  logic [AMT_W+SIDE_W-1:0] trial;
  logic                 line_ok, rcol_ok;

  assign in_ready = (state == F_IDLE);
  assign line_ok  = (SIDE_W+1)'(line_index) < (SIDE_W+1)'(side);
  assign rcol_ok  = (SIDE_W+1)'(read_column) < (SIDE_W+1)'(side);
  assign trial    = (AMT_W+SIDE_W)'(rem) - dsub;

  assign q_valid = (state == F_OUT);
  assign q_op    = op;
  assign q_col   = col;
  assign q_high  = high;
  assign q_line  = IDX_W'(line_r);
  assign q_rcol  = IDX_W'(rcol_r);
  assign q_shift = IDX_W'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            line_r <= line_index;
            rcol_r <= read_column;
            rem    <= shift_amount;
            dsub   <= (AMT_W+SIDE_W)'(side) << (AMT_W - 1);
            bitpos <= 5'(AMT_W - 1);
            col    <= (kind == KIND_UP) || (kind == KIND_DOWN);
            high   <= (kind == KIND_RIGHT) || (kind == KIND_DOWN);
            case (kind) inside
              KIND_INIT: begin
                op <= OP_FILL;
                state <= F_OUT;
              end
              KIND_LEFT, KIND_RIGHT, KIND_UP, KIND_DOWN: begin
                op <= OP_ROT;
                // drop rotations of lines outside the matrix
                state <= line_ok ? F_MOD : F_IDLE;
              end
              KIND_READ: begin
                op <= (line_ok && rcol_ok) ? OP_READ : OP_RDERR;
                state <= F_OUT;
              end
              default: state <= F_IDLE;
            endcase
          end
        end
        F_MOD: begin
          // restoring remainder, one quotient bit a cycle
          if (!trial[AMT_W+SIDE_W-1] && dsub <= (AMT_W+SIDE_W)'(rem))
            rem <= AMT_W'(trial);
          dsub <= dsub >> 1;
          bitpos <= bitpos - 5'd1;
          if (bitpos == 5'd0) state <= F_OUT;
        end
        F_OUT: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

>>> sv/mrcr_back.sv
// Back end: cell memory with start-value load, fill, rotations through a line buffer, reads.
module mrcr_back #(
  parameter int unsigned MAX_SIDE = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned SIDE_W   = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [SIDE_W-1:0]             side,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [2:0]                    q_op,
  input  logic                          q_col,
  input  logic                          q_high,
  input  logic [IDX_W-1:0]              q_line,
  input  logic [IDX_W-1:0]              q_rcol,
  input  logic [IDX_W-1:0]              q_shift,
  output logic                          done,
  output logic [mrcr_pkg::VALUE_W-1:0]  entry_value,
  output logic                          index_error
);
  import mrcr_pkg::*;

  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH  = 1 << ADDR_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_SIDE - 1);

  typedef enum logic [6:0] {
    B_INIT  = 7'b0000001,
    B_IDLE  = 7'b0000010,
    B_FILL  = 7'b0000100,
    B_LOAD  = 7'b0001000,
    B_TURN  = 7'b0010000,
    B_STORE = 7'b0100000,
    B_RD    = 7'b1000000
  } bstate_t;

  // Cell (r, c) lives at address {r, c}.
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] lbuf [MAX_SIDE];
  bstate_t            state;
  logic [IDX_W-1:0]   r_cnt, c_cnt;
  logic [VALUE_W-1:0] val;
  logic [IDX_W-1:0]   k, dst, ld_dst, wb_k, line;
  logic               col, ld_valid, wb_valid, rd_err;
  logic [IDX_W:0]     nm1;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata, lbuf_rdata;

  assign q_ready = (state == B_IDLE) && !wb_valid;
  assign nm1     = (IDX_W+1)'(side) - 1'b1;

  assign mem_we    = (state == B_INIT) || (state == B_FILL) || wb_valid;
  assign mem_waddr = wb_valid ? (col ? {wb_k, line} : {line, wb_k}) : {r_cnt, c_cnt};
  assign mem_wdata = wb_valid ? lbuf_rdata : val;
  assign mem_raddr = (state == B_LOAD) ? (col ? {k, line} : {line, k}) : {q_line, q_rcol};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (ld_valid) lbuf[ld_dst] <= mem_rdata;
    lbuf_rdata <= lbuf[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_INIT;
      r_cnt       <= '0;
      c_cnt       <= '0;
      val         <= VALUE_W'(1);
      k           <= '0;
      ld_valid    <= 1'b0;
      wb_valid    <= 1'b0;
      rd_err      <= 1'b0;
      done        <= 1'b0;
      entry_value <= '0;
      index_error <= 1'b0;
    end else begin
      done     <= (state == B_RD);
      ld_valid <= (state == B_LOAD);
      wb_valid <= (state == B_STORE);
      unique case (state)
        B_INIT: begin
          // load r*MAX_SIDE + c + 1 into every cell, one a cycle
          val <= val + 1'b1;
          if (c_cnt == LAST) begin
            c_cnt <= '0;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) state <= B_IDLE;
          end else begin
            c_cnt <= c_cnt + 1'b1;
          end
        end
        B_IDLE: begin
          if (q_valid && q_ready) begin
            line   <= q_line;
            col    <= q_col;
            k      <= '0;
            r_cnt  <= '0;
            c_cnt  <= '0;
            val    <= VALUE_W'(1);
            rd_err <= (q_op == OP_RDERR);
            // first destination of entry 0
            dst    <= q_high ? q_shift
                             : IDX_W'((IDX_W+1)'(side) - (IDX_W+1)'(q_shift));
            case (q_op) inside
              OP_FILL: state <= B_FILL;
              OP_ROT: if (q_shift != '0) state <= B_LOAD;
              OP_READ, OP_RDERR: state <= B_RD;
              default: state <= B_IDLE;
            endcase
          end
        end
        B_FILL: begin
          val <= val + 1'b1;
          if ((IDX_W+1)'(c_cnt) == nm1) begin
            c_cnt <= '0;
            r_cnt <= r_cnt + 1'b1;
            if ((IDX_W+1)'(r_cnt) == nm1) state <= B_IDLE;
          end else begin
            c_cnt <= c_cnt + 1'b1;
          end
        end
        B_LOAD: begin
          // read entry k, park it at its rotated slot of the line buffer next cycle
          ld_dst <= dst;
          dst <= ((IDX_W+1)'(dst) == nm1) ? '0 : dst + 1'b1;
          if ((IDX_W+1)'(k) == nm1) begin
            k <= '0;
            state <= B_TURN;
          end else begin
            k <= k + 1'b1;
          end
        end
        B_TURN: state <= B_STORE;
        B_STORE: begin
          wb_k <= k;
          if ((IDX_W+1)'(k) == nm1) begin
            k <= '0;
            state <= B_IDLE;
          end else begin
            k <= k + 1'b1;
          end
        end
        B_RD: begin
          entry_value <= rd_err ? '0 : mem_rdata;
          index_error <= rd_err;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
